// ----- design/rgb565_framebuffer_draw_engine_unit_defines.svh -----
// Assertion macros shared by the drawing engine RTL.
`ifndef RGB565_FRAMEBUFFER_DRAW_ENGINE_UNIT_DEFINES_SVH
`define RGB565_FRAMEBUFFER_DRAW_ENGINE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFDE_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rfde: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RFDE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rfde: next-cycle check failed");

`endif

// ----- design/rfde_pkg.sv -----
// Shared types, command codes and constants of the RGB565 drawing engine.
package rfde_pkg;

  localparam int TYPE_W  = 3;
  localparam int COORD_W = 12;
  localparam int EXT_W   = 13;
  localparam int DIM_W   = 11;
  localparam int COLOR_W = 16;
  localparam int ALPHA_W = 8;

  typedef logic [TYPE_W-1:0]         req_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [EXT_W-1:0]   ext_t;
  typedef logic [DIM_W-1:0]          dim_t;
  typedef logic [COLOR_W-1:0]        pixel_t;
  typedef logic [ALPHA_W-1:0]        alpha_t;

  localparam req_t CMD_FILL_SCREEN = 3'd0;
  localparam req_t CMD_PUT_PIXEL   = 3'd1;
  localparam req_t CMD_BLEND_PIXEL = 3'd2;
  localparam req_t CMD_RECT        = 3'd3;
  localparam req_t CMD_ROUND_RECT  = 3'd4;
  localparam req_t CMD_READ_PIXEL  = 3'd5;

  localparam alpha_t ALPHA_NONE   = 8'd0;
  localparam alpha_t ALPHA_OPAQUE = 8'd255;

  localparam pixel_t BG_RESET = 16'h0862;

endpackage

// ----- design/rfde_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
module rfde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/rfde_blend.sv -----
// Alpha blend datapath: registered channel products, then divide by 255 and repack.
module rfde_blend (
  input  logic                    clk,
  input  logic                    mix_en,
  input  rfde_pkg::pixel_t        fg_color,
  input  rfde_pkg::pixel_t        bg_color,
  input  rfde_pkg::alpha_t        alpha,
  output rfde_pkg::pixel_t        mix_color
);

  logic [15:0] r_sum_r, g_sum_r, b_sum_r;
  logic [15:0] r_sum_nxt, g_sum_nxt, b_sum_nxt;
  rfde_pkg::alpha_t inv_alpha;
  logic [7:0] fr, fg, fb, br, bg, bb;
  logic [7:0] r_q, g_q, b_q;

  // Exact floor(v / 255) for any v below 65280.
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = 17'(v) + 17'(1) + 17'(v[15:8]);
    return t[15:8];
  endfunction

  assign inv_alpha = rfde_pkg::ALPHA_OPAQUE - alpha;

  assign fr = {fg_color[15:11], 3'b000};
  assign fg = {fg_color[10:5], 2'b00};
  assign fb = {fg_color[4:0], 3'b000};
  assign br = {bg_color[15:11], 3'b000};
  assign bg = {bg_color[10:5], 2'b00};
  assign bb = {bg_color[4:0], 3'b000};

  assign r_sum_nxt = 16'(fr) * 16'(alpha) + 16'(br) * 16'(inv_alpha);
  assign g_sum_nxt = 16'(fg) * 16'(alpha) + 16'(bg) * 16'(inv_alpha);
  assign b_sum_nxt = 16'(fb) * 16'(alpha) + 16'(bb) * 16'(inv_alpha);

  always_ff @(posedge clk) begin
    if (mix_en) begin
      r_sum_r <= r_sum_nxt;
      g_sum_r <= g_sum_nxt;
      b_sum_r <= b_sum_nxt;
    end
  end

  assign r_q = div255(r_sum_r);
  assign g_q = div255(g_sum_r);
  assign b_q = div255(b_sum_r);

  assign mix_color = {r_q[7:3], g_q[7:2], b_q[7:3]};

endmodule

// ----- design/rgb565_framebuffer_draw_engine_unit.sv -----
// Top level of the RGB565 drawing engine: command sequencer around the frame store RAM.
// One command at a time. Put pixel writes; read fetches, then returns; blend does read, multiply, write.
// Fills write each clipped pixel in turn; rounded rectangles then write the background to 4 corners.
// The single frame store port sets the fill rate of one pixel per cycle.
// A result that meets a stalled output waits in a holding register and keeps the input stalled.
// Reset clears control state and loads the background color 0x0862; the frame store keeps its data.
module rgb565_framebuffer_draw_engine_unit #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  rfde_pkg::pixel_t     cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rfde_pkg::req_t       in_req_type,
  input  rfde_pkg::coord_t     in_x_pos,
  input  rfde_pkg::coord_t     in_y_pos,
  input  rfde_pkg::dim_t       in_rect_width,
  input  rfde_pkg::dim_t       in_rect_height,
  input  rfde_pkg::pixel_t     in_draw_color,
  input  rfde_pkg::alpha_t     in_alpha,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rfde_pkg::pixel_t     out_pixel_color,
  output logic                 out_read_valid
);

  `include "rgb565_framebuffer_draw_engine_unit_defines.svh"

  localparam int XW    = $clog2(SCREEN_WIDTH);
  localparam int YW    = $clog2(SCREEN_HEIGHT);
  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam rfde_pkg::ext_t SW_S = rfde_pkg::ext_t'(SCREEN_WIDTH);
  localparam rfde_pkg::ext_t SH_S = rfde_pkg::ext_t'(SCREEN_HEIGHT);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_EXEC    = 3'd1;
  localparam logic [2:0] ST_FILL    = 3'd2;
  localparam logic [2:0] ST_CORNER  = 3'd3;
  localparam logic [2:0] ST_BL_MUL  = 3'd4;
  localparam logic [2:0] ST_BL_WR   = 3'd5;
  localparam logic [2:0] ST_RD_DATA = 3'd6;
  localparam logic [2:0] ST_RES     = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [XW-1:0] walk_col_r, walk_col_nxt;
  logic [YW-1:0] walk_row_r, walk_row_nxt;
  logic [1:0] corner_r, corner_nxt;

  rfde_pkg::req_t   cmd_type_r;
  rfde_pkg::coord_t cmd_x_r, cmd_y_r;
  rfde_pkg::dim_t   cmd_w_r, cmd_h_r;
  rfde_pkg::pixel_t cmd_color_r;
  rfde_pkg::alpha_t cmd_alpha_r;
  rfde_pkg::pixel_t bg_r;

  logic [XW-1:0] x0_r;
  logic [XW:0]   x1_r;
  logic [YW:0]   y1_r;
  rfde_pkg::ext_t xe_r, ye_r;

  logic             out_valid_r, out_read_valid_r;
  rfde_pkg::pixel_t out_color_r;
  logic             pend_valid_r;
  rfde_pkg::pixel_t pend_color_r;

  logic in_accept, out_free;
  logic fin_en, fin_rv;
  rfde_pkg::pixel_t fin_color;

  rfde_pkg::ext_t px, py, rx, ry, rw, rh, x_end, y_end, x_lo, y_lo, x_hi, y_hi, cx, cy;
  logic area_ok, pix_on, corner_on, col_last, row_last;

  logic [XW-1:0] pix_col;
  logic [YW-1:0] pix_row;
  logic [AW-1:0] pix_addr;
  logic ram_we, ram_re;
  rfde_pkg::pixel_t ram_wdata, ram_rdata, mix_color;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_pixel_color = out_color_r;
  assign out_read_valid  = out_read_valid_r;

  assign px = rfde_pkg::ext_t'(cmd_x_r);
  assign py = rfde_pkg::ext_t'(cmd_y_r);
  assign rx = (cmd_type_r == rfde_pkg::CMD_FILL_SCREEN) ? '0 : px;
  assign ry = (cmd_type_r == rfde_pkg::CMD_FILL_SCREEN) ? '0 : py;
  assign rw = (cmd_type_r == rfde_pkg::CMD_FILL_SCREEN) ? SW_S : rfde_pkg::ext_t'(cmd_w_r);
  assign rh = (cmd_type_r == rfde_pkg::CMD_FILL_SCREEN) ? SH_S : rfde_pkg::ext_t'(cmd_h_r);
  assign x_end = rx + rw;
  assign y_end = ry + rh;
  assign x_lo = rx[rfde_pkg::EXT_W-1] ? '0 : rx;
  assign y_lo = ry[rfde_pkg::EXT_W-1] ? '0 : ry;
  assign x_hi = (x_end > SW_S) ? SW_S : x_end;
  assign y_hi = (y_end > SH_S) ? SH_S : y_end;
  assign area_ok = (x_hi > x_lo) && (y_hi > y_lo);

  assign pix_on = (px >= 0) && (px < SW_S) && (py >= 0) && (py < SH_S);

  assign cx = corner_r[0] ? xe_r : px;
  assign cy = corner_r[1] ? ye_r : py;
  assign corner_on = (cx >= 0) && (cx < SW_S) && (cy >= 0) && (cy < SH_S);

  assign col_last = ((XW+1)'(walk_col_r) + (XW+1)'(1)) == x1_r;
  assign row_last = ((YW+1)'(walk_row_r) + (YW+1)'(1)) == y1_r;

  always_comb begin
    case (state_r)
      ST_FILL: begin
        pix_row = walk_row_r;
        pix_col = walk_col_r;
      end
      ST_CORNER: begin
        pix_row = cy[YW-1:0];
        pix_col = cx[XW-1:0];
      end
      default: begin
        pix_row = cmd_y_r[YW-1:0];
        pix_col = cmd_x_r[XW-1:0];
      end
    endcase
  end

  assign pix_addr = AW'(pix_row) * AW'(SCREEN_WIDTH) + AW'(pix_col);

  always_comb begin
    state_nxt    = state_r;
    walk_col_nxt = walk_col_r;
    walk_row_nxt = walk_row_r;
    corner_nxt   = corner_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_wdata    = cmd_color_r;
    fin_en       = 1'b0;
    fin_rv       = 1'b0;
    fin_color    = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (cmd_type_r)
          rfde_pkg::CMD_FILL_SCREEN, rfde_pkg::CMD_RECT, rfde_pkg::CMD_ROUND_RECT: begin
            if (area_ok) begin
              state_nxt    = ST_FILL;
              walk_col_nxt = x_lo[XW-1:0];
              walk_row_nxt = y_lo[YW-1:0];
            end else if (cmd_type_r == rfde_pkg::CMD_ROUND_RECT) begin
              state_nxt  = ST_CORNER;
              corner_nxt = 2'd0;
            end else begin
              fin_en = 1'b1;
            end
          end
          rfde_pkg::CMD_PUT_PIXEL: begin
            ram_we = pix_on;
            fin_en = 1'b1;
          end
          rfde_pkg::CMD_BLEND_PIXEL: begin
            if (!pix_on || cmd_alpha_r == rfde_pkg::ALPHA_NONE) begin
              fin_en = 1'b1;
            end else if (cmd_alpha_r == rfde_pkg::ALPHA_OPAQUE) begin
              ram_we = 1'b1;
              fin_en = 1'b1;
            end else begin
              ram_re    = 1'b1;
              state_nxt = ST_BL_MUL;
            end
          end
          rfde_pkg::CMD_READ_PIXEL: begin
            if (pix_on) begin
              ram_re    = 1'b1;
              state_nxt = ST_RD_DATA;
            end else begin
              fin_en = 1'b1;
            end
          end
          default: begin
            fin_en = 1'b1;
          end
        endcase
      end
      ST_FILL: begin
        ram_we = 1'b1;
        if (col_last) begin
          walk_col_nxt = x0_r;
          if (row_last) begin
            walk_col_nxt = '0;
            walk_row_nxt = '0;
            if (cmd_type_r == rfde_pkg::CMD_ROUND_RECT) begin
              state_nxt  = ST_CORNER;
              corner_nxt = 2'd0;
            end else begin
              fin_en = 1'b1;
            end
          end else begin
            walk_row_nxt = walk_row_r + YW'(1);
          end
        end else begin
          walk_col_nxt = walk_col_r + XW'(1);
        end
      end
      ST_CORNER: begin
        ram_we     = corner_on;
        ram_wdata  = bg_r;
        corner_nxt = corner_r + 2'd1;
        if (corner_r == 2'd3) begin
          fin_en = 1'b1;
        end
      end
      ST_BL_MUL: begin
        state_nxt = ST_BL_WR;
      end
      ST_BL_WR: begin
        ram_we    = 1'b1;
        ram_wdata = mix_color;
        fin_en    = 1'b1;
      end
      ST_RD_DATA: begin
        fin_en    = 1'b1;
        fin_rv    = 1'b1;
        fin_color = ram_rdata;
      end
      ST_RES: begin
        fin_en    = 1'b1;
        fin_rv    = pend_valid_r;
        fin_color = pend_color_r;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (fin_en) begin
      state_nxt = out_free ? ST_IDLE : ST_RES;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      walk_col_r  <= '0;
      walk_row_r  <= '0;
      corner_r    <= '0;
      bg_r        <= rfde_pkg::BG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      walk_col_r <= walk_col_nxt;
      walk_row_r <= walk_row_nxt;
      corner_r   <= corner_nxt;
      if (cfg_wr_en) begin
        bg_r <= cfg_wr_data;
      end
      if (fin_en && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_type_r  <= in_req_type;
      cmd_x_r     <= in_x_pos;
      cmd_y_r     <= in_y_pos;
      cmd_w_r     <= in_rect_width;
      cmd_h_r     <= in_rect_height;
      cmd_color_r <= in_draw_color;
      cmd_alpha_r <= in_alpha;
    end
    if (state_r == ST_EXEC) begin
      x0_r <= x_lo[XW-1:0];
      x1_r <= x_hi[XW:0];
      y1_r <= y_hi[YW:0];
      xe_r <= x_end - rfde_pkg::ext_t'(1);
      ye_r <= y_end - rfde_pkg::ext_t'(1);
    end
    if (fin_en && out_free) begin
      out_color_r      <= fin_color;
      out_read_valid_r <= fin_rv;
    end
    if (fin_en && !out_free) begin
      pend_color_r <= fin_color;
      pend_valid_r <= fin_rv;
    end
  end

  rfde_ram #(
    .WIDTH(rfde_pkg::COLOR_W),
    .DEPTH(DEPTH)
  ) u_frame_store (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(pix_addr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(pix_addr),
    .rd_data(ram_rdata)
  );

  rfde_blend u_blend (
    .clk      (clk),
    .mix_en   (state_r == ST_BL_MUL),
    .fg_color (cmd_color_r),
    .bg_color (ram_rdata),
    .alpha    (cmd_alpha_r),
    .mix_color(mix_color)
  );

  `RFDE_ASSERT_NEXT(a_accept_blocks, clk, rst_n, in_valid && !in_stall, in_stall)
  `RFDE_ASSERT_NOW(a_no_rw_overlap, clk, rst_n, ram_re, !ram_we)
  `RFDE_ASSERT_NOW(a_walk_in_bounds, clk, rst_n, state_r == ST_FILL,
                   ((XW+1)'(walk_col_r) < x1_r) && ((YW+1)'(walk_row_r) < y1_r))
  `RFDE_ASSERT_NOW(a_color_only_on_read, clk, rst_n, out_valid && !out_read_valid, out_pixel_color == '0)
  `RFDE_ASSERT_NOW(a_pending_needs_busy_out, clk, rst_n, state_r == ST_RES, out_valid_r)

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench of the RGB565 drawing engine with a shadow frame store.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCREEN_W    = 128;
  localparam int SCREEN_H    = 128;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int MAX_SHOWN   = 10;
  localparam int DRAIN_TAIL  = 50;

  localparam rfde_pkg::req_t CMD_UNUSED_6 = 3'd6;
  localparam rfde_pkg::req_t CMD_UNUSED_7 = 3'd7;

  typedef struct {
    rfde_pkg::req_t   kind;
    rfde_pkg::coord_t x;
    rfde_pkg::coord_t y;
    rfde_pkg::dim_t   w;
    rfde_pkg::dim_t   h;
    rfde_pkg::pixel_t color;
    rfde_pkg::alpha_t alpha;
  } draw_cmd_t;

  typedef struct {
    rfde_pkg::pixel_t color;
    logic             rd_ok;
  } reply_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  rfde_pkg::pixel_t cfg_wr_data;
  logic             in_valid;
  logic             in_stall;
  rfde_pkg::req_t   in_req_type;
  rfde_pkg::coord_t in_x_pos;
  rfde_pkg::coord_t in_y_pos;
  rfde_pkg::dim_t   in_rect_width;
  rfde_pkg::dim_t   in_rect_height;
  rfde_pkg::pixel_t in_draw_color;
  rfde_pkg::alpha_t in_alpha;
  logic             out_valid;
  logic             out_stall;
  rfde_pkg::pixel_t out_pixel_color;
  logic             out_read_valid;

  rfde_pkg::pixel_t shadow_fb [SCREEN_W*SCREEN_H];
  rfde_pkg::pixel_t shadow_bg;
  reply_t pending_replies [$];

  int cycle_count;
  int error_count;
  int replies_checked;
  int bg_writes;
  int kind_count [8];
  int send_idle_pct;
  int recv_stall_pct;
  int holdoff_cycles;

  rgb565_framebuffer_draw_engine_unit #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_x_pos       (in_x_pos),
    .in_y_pos       (in_y_pos),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_draw_color  (in_draw_color),
    .in_alpha       (in_alpha),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_color(out_pixel_color),
    .out_read_valid (out_read_valid)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit on_screen(int x, int y);
    return x >= 0 && x < SCREEN_W && y >= 0 && y < SCREEN_H;
  endfunction

  function automatic void plot_px(int x, int y, rfde_pkg::pixel_t c);
    if (on_screen(x, y)) shadow_fb[y*SCREEN_W + x] = c;
  endfunction

  function automatic rfde_pkg::pixel_t mix565(rfde_pkg::pixel_t fg, rfde_pkg::pixel_t bg,
                                              int a);
    int f, k, na, r, g, b;
    f  = fg;
    k  = bg;
    na = 255 - a;
    r  = ((f >> 11) << 3) * a + ((k >> 11) << 3) * na;
    g  = (((f >> 5) & 'h3F) << 2) * a + (((k >> 5) & 'h3F) << 2) * na;
    b  = ((f & 'h1F) << 3) * a + ((k & 'h1F) << 3) * na;
    r  = r / 255;
    g  = g / 255;
    b  = b / 255;
    return rfde_pkg::pixel_t'(((r & 'hF8) << 8) | ((g & 'hFC) << 3) | ((b & 'hF8) >> 3));
  endfunction

  function automatic void fill_area(int x, int y, int w, int h, rfde_pkg::pixel_t c);
    int x0, y0, x1, y1;
    x0 = (x < 0) ? 0 : x;
    y0 = (y < 0) ? 0 : y;
    x1 = (x + w > SCREEN_W) ? SCREEN_W : x + w;
    y1 = (y + h > SCREEN_H) ? SCREEN_H : y + h;
    for (int j = y0; j < y1; j++) begin
      for (int i = x0; i < x1; i++) begin
        shadow_fb[j*SCREEN_W + i] = c;
      end
    end
  endfunction

  function automatic reply_t render_cmd(draw_cmd_t c);
    reply_t r;
    int     x, y, w, h, idx;
    r.color = '0;
    r.rd_ok = 1'b0;
    x = c.x;
    y = c.y;
    w = c.w;
    h = c.h;
    case (c.kind)
      rfde_pkg::CMD_FILL_SCREEN: fill_area(0, 0, SCREEN_W, SCREEN_H, c.color);
      rfde_pkg::CMD_PUT_PIXEL:   plot_px(x, y, c.color);
      rfde_pkg::CMD_BLEND_PIXEL: begin
        if (on_screen(x, y) && c.alpha != rfde_pkg::ALPHA_NONE) begin
          idx = y*SCREEN_W + x;
          shadow_fb[idx] = (c.alpha == rfde_pkg::ALPHA_OPAQUE) ? c.color
                                                     : mix565(c.color, shadow_fb[idx], c.alpha);
        end
      end
      rfde_pkg::CMD_RECT:        fill_area(x, y, w, h, c.color);
      rfde_pkg::CMD_ROUND_RECT: begin
        fill_area(x, y, w, h, c.color);
        plot_px(x, y, shadow_bg);
        plot_px(x + w - 1, y, shadow_bg);
        plot_px(x, y + h - 1, shadow_bg);
        plot_px(x + w - 1, y + h - 1, shadow_bg);
      end
      rfde_pkg::CMD_READ_PIXEL: begin
        if (on_screen(x, y)) begin
          r.color = shadow_fb[y*SCREEN_W + x];
          r.rd_ok = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= MAX_SHOWN) $display("ERROR at cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic draw_cmd_t mk_cmd(rfde_pkg::req_t k, int x, int y, int w, int h,
                                       int color, int alpha);
    draw_cmd_t c;
    c.kind  = k;
    c.x     = rfde_pkg::coord_t'(x);
    c.y     = rfde_pkg::coord_t'(y);
    c.w     = rfde_pkg::dim_t'(w);
    c.h     = rfde_pkg::dim_t'(h);
    c.color = rfde_pkg::pixel_t'(color);
    c.alpha = rfde_pkg::alpha_t'(alpha);
    return c;
  endfunction

  function automatic rfde_pkg::coord_t rand_coord();
    if ($urandom_range(0, 99) < 15) return rfde_pkg::coord_t'($urandom);
    return rfde_pkg::coord_t'(int'($urandom_range(0, 135)) - 4);
  endfunction

  function automatic rfde_pkg::dim_t rand_dim();
    int p;
    p = $urandom_range(0, 99);
    if (p < 94) return rfde_pkg::dim_t'($urandom_range(0, 12));
    if (p < 98) return rfde_pkg::dim_t'($urandom_range(0, 140));
    return rfde_pkg::dim_t'($urandom);
  endfunction

  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int        p;
    p = $urandom_range(0, 999);
    if (p < 5)        c.kind = rfde_pkg::CMD_FILL_SCREEN;
    else if (p < 255) c.kind = rfde_pkg::CMD_PUT_PIXEL;
    else if (p < 505) c.kind = rfde_pkg::CMD_BLEND_PIXEL;
    else if (p < 755) c.kind = rfde_pkg::CMD_READ_PIXEL;
    else if (p < 875) c.kind = rfde_pkg::CMD_RECT;
    else if (p < 975) c.kind = rfde_pkg::CMD_ROUND_RECT;
    else if (p < 990) c.kind = CMD_UNUSED_6;
    else              c.kind = CMD_UNUSED_7;
    c.x     = rand_coord();
    c.y     = rand_coord();
    c.w     = rfde_pkg::dim_t'($urandom);
    c.h     = rfde_pkg::dim_t'($urandom);
    if (c.kind == rfde_pkg::CMD_RECT || c.kind == rfde_pkg::CMD_ROUND_RECT) begin
      c.w = rand_dim();
      c.h = rand_dim();
    end
    c.color = rfde_pkg::pixel_t'($urandom);
    p = $urandom_range(0, 99);
    c.alpha = (p < 10) ? rfde_pkg::ALPHA_NONE :
              (p < 20) ? rfde_pkg::ALPHA_OPAQUE : rfde_pkg::alpha_t'($urandom);
    return c;
  endfunction

  task automatic send_cmd(draw_cmd_t c);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= c.kind;
    in_x_pos       <= c.x;
    in_y_pos       <= c.y;
    in_rect_width  <= c.w;
    in_rect_height <= c.h;
    in_draw_color  <= c.color;
    in_alpha       <= c.alpha;
    do @(posedge clk); while (in_stall);
    kind_count[c.kind]++;
    pending_replies.push_back(render_cmd(c));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_background(rfde_pkg::pixel_t value);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_bg = value;
    bg_writes++;
  endtask

  task automatic run_random_phase(int n_items, int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n_items) send_cmd(random_cmd());
    wait_drained();
  endtask

  task automatic test_screen_fill();
    send_cmd(mk_cmd(rfde_pkg::CMD_FILL_SCREEN, -2048, 2047, 2047, 2047, 'h0000, 255));
    send_cmd(mk_cmd(rfde_pkg::CMD_READ_PIXEL, 0, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(rfde_pkg::CMD_READ_PIXEL, 127, 127, 0, 0, 0, 0));
  endtask

  task automatic test_corner_background_reset();
    send_cmd(mk_cmd(rfde_pkg::CMD_ROUND_RECT, 2, 2, 4, 3, 'hFFFF, 0));
    send_cmd(mk_cmd(rfde_pkg::CMD_READ_PIXEL, 2, 2, 0, 0, 0, 0));
    send_cmd(mk_cmd(rfde_pkg::CMD_READ_PIXEL, 3, 2, 0, 0, 0, 0));
  endtask

  task automatic test_pixel_writes_and_reads();
    send_cmd(mk_cmd(rfde_pkg::CMD_PUT_PIXEL, 0, 0, 0, 0, 'hFFFF, 0));
    send_cmd(mk_cmd(rfde_pkg::CMD_PUT_PIXEL, 127, 127, 0, 0, 'hA5A5, 255));
    send_cmd(mk_cmd(rfde_pkg::CMD_PUT_PIXEL, -1, 0, 0, 0, 'h1234, 0));
    send_cmd(mk_cmd(rfde_pkg::CMD_PUT_PIXEL, 2047, -2048, 2047, 2047, 'h4321, 0));
    send_cmd(mk_cmd(rfde_pkg::CMD_READ_PIXEL, 0, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(rfde_pkg::CMD_READ_PIXEL, 127, 127, 0, 0, 0, 0));
    send_cmd(mk_cmd(rfde_pkg::CMD_READ_PIXEL, -1, 5, 0, 0, 0, 0));
    send_cmd(mk_cmd(rfde_pkg::CMD_READ_PIXEL, -2048, 2047, 0, 0, 0, 0));
  endtask

  task automatic test_pixel_blending();
    send_cmd(mk_cmd(rfde_pkg::CMD_BLEND_PIXEL, 10, 10, 0, 0, 'hFFFF, rfde_pkg::ALPHA_NONE));
    send_cmd(mk_cmd(rfde_pkg::CMD_BLEND_PIXEL, 10, 10, 0, 0, 'hF81F, rfde_pkg::ALPHA_OPAQUE));
    send_cmd(mk_cmd(rfde_pkg::CMD_BLEND_PIXEL, 10, 10, 0, 0, 'h07E0, 1));
    send_cmd(mk_cmd(rfde_pkg::CMD_BLEND_PIXEL, 10, 10, 0, 0, 'h07E0, 128));
    send_cmd(mk_cmd(rfde_pkg::CMD_BLEND_PIXEL, 10, 10, 0, 0, 'h001F, 254));
    send_cmd(mk_cmd(rfde_pkg::CMD_BLEND_PIXEL, -5, 3, 0, 0, 'hFFFF, 128));
    send_cmd(mk_cmd(rfde_pkg::CMD_READ_PIXEL, 10, 10, 0, 0, 0, 0));
  endtask

  task automatic test_rectangles();
    send_cmd(mk_cmd(rfde_pkg::CMD_RECT, 20, 20, 0, 5, 'h1111, 0));
    send_cmd(mk_cmd(rfde_pkg::CMD_RECT, 20, 20, 5, 0, 'h2222, 0));
    send_cmd(mk_cmd(rfde_pkg::CMD_RECT, 120, 120, 2047, 2047, 'h3333, 0));
    send_cmd(mk_cmd(rfde_pkg::CMD_ROUND_RECT, 5, 5, 0, 0, 'h4444, 0));
    send_cmd(mk_cmd(rfde_pkg::CMD_ROUND_RECT, -1, -1, 3, 3, 'h5555, 0));
    send_cmd(mk_cmd(rfde_pkg::CMD_READ_PIXEL, 127, 127, 0, 0, 0, 0));
  endtask

  task automatic test_unused_codes();
    send_cmd(mk_cmd(CMD_UNUSED_6, 1, 1, 4, 4, 'hFFFF, 255));
    send_cmd(mk_cmd(CMD_UNUSED_7, 1, 1, 4, 4, 'hFFFF, 255));
  endtask

  task automatic test_background_settings_random();
    write_background('h0000);
    run_random_phase(480, 0, 0);
    write_background('hFFFF);
    run_random_phase(480, 76, 0);
    write_background(rfde_pkg::pixel_t'($urandom));
    run_random_phase(480, 0, 76);
    write_background(rfde_pkg::pixel_t'($urandom));
    run_random_phase(480, 24, 24);
  endtask

  task automatic test_input_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_cycles = 300;
    repeat (12) send_cmd(random_cmd());
  endtask

  task automatic test_drain_pause();
    wait_drained();
    repeat (8) send_cmd(random_cmd());
    wait_drained();
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_cycles > 0) begin
        out_stall <= 1'b1;
        holdoff_cycles--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    reply_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        flag_error("reply beat with no command outstanding");
      end else begin
        exp_r = pending_replies.pop_front();
        replies_checked++;
        if (out_pixel_color !== exp_r.color)
          flag_error($sformatf("pixel_color expected %h, got %h", exp_r.color,
                               out_pixel_color));
        if (out_read_valid !== exp_r.rd_ok)
          flag_error($sformatf("read_valid expected %b, got %b", exp_r.rd_ok,
                               out_read_valid));
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_req_type    = '0;
    in_x_pos       = '0;
    in_y_pos       = '0;
    in_rect_width  = '0;
    in_rect_height = '0;
    in_draw_color  = '0;
    in_alpha       = '0;
    error_count    = 0;
    replies_checked = 0;
    bg_writes      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_cycles = 0;
    shadow_bg      = rfde_pkg::BG_RESET;
    foreach (kind_count[i]) kind_count[i] = 0;
    foreach (shadow_fb[i]) shadow_fb[i] = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_screen_fill();
    test_corner_background_reset();
    test_pixel_writes_and_reads();
    test_pixel_blending();
    test_rectangles();
    test_unused_codes();
    test_input_backpressure();
    test_drain_pause();
    test_background_settings_random();

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    $display("Drew %0d fills, %0d puts, %0d blends, %0d rects, %0d rounded rects, %0d reads",
             kind_count[rfde_pkg::CMD_FILL_SCREEN], kind_count[rfde_pkg::CMD_PUT_PIXEL],
             kind_count[rfde_pkg::CMD_BLEND_PIXEL], kind_count[rfde_pkg::CMD_RECT],
             kind_count[rfde_pkg::CMD_ROUND_RECT], kind_count[rfde_pkg::CMD_READ_PIXEL]);
    $display("plus %0d unused codes; %0d replies checked across %0d background writes",
             kind_count[CMD_UNUSED_6] + kind_count[CMD_UNUSED_7], replies_checked, bg_writes);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches in total", error_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
